// ----- rtl/itpa_pkg.sv -----
// ----------------------------------------------------------------------------
// itpa_pkg
// types and constants for the integer to padded ascii converter
// ----------------------------------------------------------------------------
package itpa_pkg;

    localparam int NUM_DIGITS = 22;
    localparam int DIG_BITS   = 4 * NUM_DIGITS;
    localparam int BCD_DIGITS = 20;
    localparam logic [5:0] MAX_FIELD = 6'd60;

    localparam logic [1:0] RADIX_DEC  = 2'd0;
    localparam logic [1:0] RADIX_OCT  = 2'd1;
    localparam logic [1:0] RADIX_HEX  = 2'd2;
    localparam logic [1:0] RADIX_RSVD = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [63:0] value;
        logic        is_wide;
        logic        twos_comp;
        logic [1:0]  radix;
        logic [5:0]  field_width;
        logic [5:0]  min_digits;
        logic        has_precision;
        logic        pad_right;
        logic        zero_pad;
        logic        force_plus;
        logic        space_sign;
        logic        alternate_form;
    } in_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_t;

endpackage

// ----- rtl/integer_to_padded_ascii_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_padded_ascii_top
// printf-style %d/%o/%x conversion, one ascii character per strobe
// ----------------------------------------------------------------------------
// sequence: accept, then for decimal a shift-and-add-3 binary to bcd
// conversion, leading-zero shifting, a layout step and one character a cycle
// within a segment, pausing at each segment change; octal and hex skip the conversion.
// one item at a time: busy stays high until the last character is out.
// the receiver cannot stall. reset clears the sequencer, digits need none.
// ----------------------------------------------------------------------------
module integer_to_padded_ascii_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  itpa_pkg::in_t  arg,
    output logic           busy,
    output logic           strobe,
    output itpa_pkg::out_t result
);
    import itpa_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_CONV, ST_NORM, ST_LAYOUT, ST_EMIT} state_t;
    typedef enum logic [3:0] {
        SG_START, SG_PADL, SG_SIGN, SG_PADZ, SG_PFX0, SG_PFXX, SG_ZEROS, SG_DIGITS, SG_PADR
    } seg_t;

    state_t state_reg;
    seg_t   seg_reg;
    seg_t   seg_next;
    in_t    arg_reg;
    logic [63:0] val_reg;
    logic [DIG_BITS-1:0] dig_reg;
    logic [5:0] bit_cnt_reg;
    logic [4:0] ndig_reg;
    logic [7:0] sign_ch_reg;
    logic       has_sign_reg;
    logic       qlen_reg;
    logic [5:0] zeros_reg;
    logic [5:0] pad_reg;
    logic [5:0] cnt_reg;
    logic [5:0] rem_reg;
    logic [5:0] seg_len;

    logic [63:0] raw, mag;
    logic        neg;
    logic [65:0] magx;
    logic [DIG_BITS-1:0] load_dig;
    logic [4*BCD_DIGITS-1:0] bcd_adj;
    logic [5:0] width_s, prec_s, prec_f, zeros_c;
    logic       qlen_c;
    logic [6:0] body_c, total_c;
    logic [5:0] pad_c;
    logic [3:0] top_d;
    logic [7:0] cur_ch;

    always_comb
    begin
        raw = arg.is_wide ? arg.value : {{32{arg.value[31]}}, arg.value[31:0]};
        neg = arg.twos_comp && raw[63];
        mag = neg ? (~raw + 64'd1) : raw;
        if (!arg.is_wide)
        begin
            mag[63:32] = 32'd0;
        end
        magx = {2'b00, mag};
        load_dig = '0;
        if (arg.radix == RADIX_OCT)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                load_dig[4*i +: 4] = {1'b0, magx[3*i +: 3]};
            end
        end
        else if (arg.radix == RADIX_HEX)
        begin
            for (int i = 0; i < 16; i++)
            begin
                load_dig[4*i +: 4] = mag[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                (dig_reg[4*i +: 4] + 4'd3) : dig_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        width_s = (arg_reg.field_width > MAX_FIELD) ? MAX_FIELD : arg_reg.field_width;
        prec_s  = arg_reg.has_precision ? arg_reg.min_digits : 6'd1;
        if (prec_s > MAX_FIELD)
        begin
            prec_s = MAX_FIELD;
        end
        prec_f = prec_s;
        if (arg_reg.alternate_form && arg_reg.radix == RADIX_OCT
            && prec_s <= {1'b0, ndig_reg})
        begin
            prec_f = {1'b0, ndig_reg} + 6'd1;
        end
        qlen_c  = arg_reg.alternate_form && arg_reg.radix == RADIX_HEX
                  && ndig_reg != 5'd0;
        zeros_c = (prec_f > {1'b0, ndig_reg}) ? (prec_f - {1'b0, ndig_reg}) : 6'd0;
        body_c  = {6'd0, has_sign_reg} + {5'd0, qlen_c, 1'b0} + {1'b0, zeros_c}
                + {2'd0, ndig_reg};
        pad_c   = ({1'b0, width_s} > body_c) ? (width_s - body_c[5:0]) : 6'd0;
        total_c = body_c + {1'b0, pad_c};
    end

    always_comb
    begin
        case (seg_reg)
            SG_START:  seg_next = SG_PADL;
            SG_PADL:   seg_next = SG_SIGN;
            SG_SIGN:   seg_next = SG_PADZ;
            SG_PADZ:   seg_next = SG_PFX0;
            SG_PFX0:   seg_next = SG_PFXX;
            SG_PFXX:   seg_next = SG_ZEROS;
            SG_ZEROS:  seg_next = SG_DIGITS;
            SG_DIGITS: seg_next = SG_PADR;
            default:   seg_next = SG_PADR;
        endcase
        case (seg_next)
            SG_PADL:   seg_len = (!arg_reg.pad_right && !arg_reg.zero_pad) ? pad_reg : 6'd0;
            SG_SIGN:   seg_len = {5'd0, has_sign_reg};
            SG_PADZ:   seg_len = (!arg_reg.pad_right && arg_reg.zero_pad) ? pad_reg : 6'd0;
            SG_PFX0:   seg_len = {5'd0, qlen_reg};
            SG_PFXX:   seg_len = {5'd0, qlen_reg};
            SG_ZEROS:  seg_len = zeros_reg;
            SG_DIGITS: seg_len = {1'b0, ndig_reg};
            SG_PADR:   seg_len = arg_reg.pad_right ? pad_reg : 6'd0;
            default:   seg_len = 6'd0;
        endcase
    end

    always_comb
    begin
        top_d = dig_reg[DIG_BITS-1 -: 4];
        case (seg_reg)
            SG_PADL:   cur_ch = CH_SPACE;
            SG_SIGN:   cur_ch = sign_ch_reg;
            SG_PFXX:   cur_ch = CH_X;
            SG_DIGITS: cur_ch = (top_d < 4'd10) ? (CH_ZERO + {4'd0, top_d})
                                                : (CH_LOWA + {4'd0, top_d} - 8'd10);
            SG_PADR:   cur_ch = arg_reg.zero_pad ? CH_ZERO : CH_SPACE;
            default:   cur_ch = CH_ZERO;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= SG_START;
            strobe    <= 1'b0;
        end
        else
        begin
            strobe <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        arg_reg      <= arg;
                        val_reg      <= mag;
                        dig_reg      <= load_dig;
                        bit_cnt_reg  <= 6'd63;
                        ndig_reg     <= 5'(NUM_DIGITS);
                        has_sign_reg <= arg.twos_comp &&
                                        (neg || arg.force_plus || arg.space_sign);
                        sign_ch_reg  <= neg ? CH_MINUS : (arg.force_plus ? CH_PLUS : CH_SPACE);
                        state_reg    <= (arg.radix == RADIX_OCT || arg.radix == RADIX_HEX) ?
                                        ST_NORM : ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    dig_reg   <= {8'd0, bcd_adj[4*BCD_DIGITS-2:0], val_reg[63]};
                    val_reg   <= {val_reg[62:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg - 6'd1;
                    if (bit_cnt_reg == 6'd0)
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    if (ndig_reg == 5'd0 || top_d != 4'd0)
                    begin
                        state_reg <= ST_LAYOUT;
                    end
                    else
                    begin
                        dig_reg  <= {dig_reg[DIG_BITS-5:0], 4'd0};
                        ndig_reg <= ndig_reg - 5'd1;
                    end
                end
                ST_LAYOUT:
                begin
                    qlen_reg  <= qlen_c;
                    zeros_reg <= zeros_c;
                    pad_reg   <= pad_c;
                    rem_reg   <= total_c[5:0];
                    seg_reg   <= SG_START;
                    cnt_reg   <= 6'd0;
                    state_reg <= (total_c == 7'd0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        seg_reg <= seg_next;
                        cnt_reg <= seg_len;
                    end
                    else
                    begin
                        strobe          <= 1'b1;
                        result.out_char <= cur_ch;
                        result.last     <= (rem_reg == 6'd1);
                        cnt_reg         <= cnt_reg - 6'd1;
                        rem_reg         <= rem_reg - 6'd1;
                        if (seg_reg == SG_DIGITS)
                        begin
                            dig_reg <= {dig_reg[DIG_BITS-5:0], 4'd0};
                        end
                        if (rem_reg == 6'd1)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- dv/integer_to_padded_ascii_top_tb.sv -----
// ----------------------------------------------------------------------------
// integer_to_padded_ascii_top_tb
// self-checking bench: formatted characters compared against a local layout
// model, with directed corner cases, random items and random sender gaps
// ----------------------------------------------------------------------------
module integer_to_padded_ascii_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import itpa_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    in_t  arg;
    logic busy;
    logic strobe;
    out_t result;

    out_t expected_chars[$];
    int   error_count;
    int   sender_idle_pct;

    integer_to_padded_ascii_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .arg    (arg),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #5ms;
        $display("** integer_to_padded_ascii_top: FAILED **");
        $finish;
    end

    function automatic void format_field(in_t a);
        logic [63:0] raw;
        logic [63:0] mag;
        logic [3:0]  digits[0:31];
        logic [3:0]  d;
        logic [7:0]  sign_ch;
        logic [7:0]  pad_ch;
        logic [1:0]  rdx;
        int          n_dig;
        int          width;
        int          prec;
        int          prefix_len;
        int          zeros;
        int          body;
        int          pad;
        out_t        c;
        logic [7:0]  seq[$];

        rdx = (a.radix == RADIX_RSVD) ? RADIX_DEC : a.radix;
        raw = a.is_wide ? a.value : {{32{a.value[31]}}, a.value[31:0]};
        mag = raw;
        sign_ch = 8'h00;
        if (a.twos_comp)
        begin
            if (raw[63])
            begin
                mag = ~raw + 64'd1;
                sign_ch = CH_MINUS;
            end
            else if (a.force_plus)
                sign_ch = CH_PLUS;
            else if (a.space_sign)
                sign_ch = CH_SPACE;
        end
        if (!a.is_wide)
            mag = {32'd0, mag[31:0]};

        n_dig = 0;
        while (mag != 64'd0)
        begin
            if (rdx == RADIX_OCT)
            begin
                d = {1'b0, mag[2:0]};
                mag = mag >> 3;
            end
            else if (rdx == RADIX_HEX)
            begin
                d = mag[3:0];
                mag = mag >> 4;
            end
            else
            begin
                d = 4'(mag % 64'd10);
                mag = mag / 64'd10;
            end
            digits[n_dig] = d;
            n_dig++;
        end

        width = (a.field_width > MAX_FIELD) ? int'(MAX_FIELD) : int'(a.field_width);
        prec = a.has_precision ? int'(a.min_digits) : 1;
        if (prec > int'(MAX_FIELD))
            prec = int'(MAX_FIELD);
        prefix_len = 0;
        if (a.alternate_form)
        begin
            if (rdx == RADIX_OCT && prec <= n_dig)
                prec = n_dig + 1;
            else if (rdx == RADIX_HEX && n_dig != 0)
                prefix_len = 2;
        end
        zeros = (prec > n_dig) ? prec - n_dig : 0;
        body = ((sign_ch != 8'h00) ? 1 : 0) + prefix_len + zeros + n_dig;
        pad = (width > body) ? width - body : 0;
        pad_ch = a.zero_pad ? CH_ZERO : CH_SPACE;

        if (!a.pad_right && !a.zero_pad)
            repeat (pad) seq.push_back(CH_SPACE);
        if (sign_ch != 8'h00)
            seq.push_back(sign_ch);
        if (!a.pad_right && a.zero_pad)
            repeat (pad) seq.push_back(CH_ZERO);
        if (prefix_len != 0)
        begin
            seq.push_back(CH_ZERO);
            seq.push_back(CH_X);
        end
        repeat (zeros) seq.push_back(CH_ZERO);
        for (int i = n_dig - 1; i >= 0; i--)
            seq.push_back(digits[i] < 4'd10 ? CH_ZERO + 8'(digits[i])
                                            : CH_LOWA + 8'(digits[i] - 4'd10));
        if (a.pad_right)
            repeat (pad) seq.push_back(pad_ch);

        foreach (seq[i])
        begin
            c.out_char = seq[i];
            c.last = (i == seq.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected character 0x%02h", result.out_char);
                error_count++;
            end
            else
            begin
                out_t e;
                e = expected_chars.pop_front();
                if (result.out_char !== e.out_char)
                begin
                    $error("out_char expected 0x%02h actual 0x%02h",
                           e.out_char, result.out_char);
                    error_count++;
                end
                if (result.last !== e.last)
                begin
                    $error("last expected %0b actual %0b", e.last, result.last);
                    error_count++;
                end
            end
        end
    end

    task automatic send_item(in_t a);
        int gap;
        arg   <= a;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        format_field(a);
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
            gap = $urandom_range(1, 12);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic in_t make_arg(logic [63:0] v, bit wide, bit sgn, logic [1:0] rdx,
                                     int fw, int md, bit hp, bit lj, bit zp,
                                     bit fp, bit sp, bit af);
        in_t a;
        a.value = v;
        a.is_wide = wide;
        a.twos_comp = sgn;
        a.radix = rdx;
        a.field_width = 6'(fw);
        a.min_digits = 6'(md);
        a.has_precision = hp;
        a.pad_right = lj;
        a.zero_pad = zp;
        a.force_plus = fp;
        a.space_sign = sp;
        a.alternate_form = af;
        return a;
    endfunction

    function automatic in_t random_arg();
        in_t         a;
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        a = r[$bits(in_t)-1:0];
        case ($urandom_range(5))
            0: a.value = 64'd0;
            1: a.value = 64'($urandom_range(999));
            2: a.value = {$urandom, $urandom};
            3: a.value = {32'($urandom), 32'h8000_0000 | 32'($urandom_range(15))};
            4: a.value = {1'b1, 63'($urandom_range(7))};
            default: a.value = ~64'($urandom_range(255));
        endcase
        if ($urandom_range(3) != 0)
            a.field_width = 6'($urandom_range(12));
        if ($urandom_range(3) != 0)
            a.min_digits = 6'($urandom_range(4));
        return a;
    endfunction

    task automatic wait_drained();
        while (expected_chars.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic test_corner_cases();
        sender_idle_pct = 20;
        send_item(make_arg(64'd0, 1, 0, RADIX_DEC, 0, 0, 1, 0, 0, 0, 0, 0));
        send_item(make_arg(64'd0, 1, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_arg(64'd0, 1, 0, RADIX_DEC, 5, 0, 1, 1, 1, 0, 0, 0));
        send_item(make_arg('1, 1, 0, RADIX_DEC, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_arg(64'h8000_0000_0000_0000, 1, 1, RADIX_DEC, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_arg(64'h8000_0000_0000_0000, 1, 1, RADIX_OCT, 0, 0, 0, 0, 0, 0, 0, 1));
        send_item(make_arg(64'hFFFF_FFFF_8000_0000, 0, 1, RADIX_DEC, 14, 0, 0, 0, 1, 0, 0, 0));
        send_item(make_arg(64'h0000_0000_FFFF_FFFF, 0, 0, RADIX_HEX, 0, 0, 0, 0, 0, 0, 0, 1));
        send_item(make_arg('1, 1, 0, RADIX_OCT, 0, 0, 0, 0, 0, 0, 0, 1));
        send_item(make_arg(64'd0, 1, 0, RADIX_OCT, 0, 0, 1, 0, 0, 0, 0, 1));
        send_item(make_arg(64'd0, 1, 0, RADIX_HEX, 4, 0, 1, 0, 0, 0, 0, 1));
        send_item(make_arg(64'h2a, 1, 0, RADIX_HEX, 10, 0, 0, 0, 1, 0, 0, 1));
        send_item(make_arg(64'h2a, 1, 0, RADIX_HEX, 10, 4, 1, 1, 1, 0, 0, 1));
        send_item(make_arg(64'd42, 1, 1, RADIX_DEC, 6, 0, 0, 0, 0, 1, 0, 0));
        send_item(make_arg(64'd42, 1, 1, RADIX_DEC, 6, 0, 0, 1, 0, 0, 1, 0));
        send_item(make_arg(64'd42, 1, 1, RADIX_DEC, 6, 0, 0, 0, 1, 1, 1, 0));
        send_item(make_arg(64'd1234, 1, 0, RADIX_RSVD, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_arg(64'd7, 1, 0, RADIX_DEC, 63, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_arg(64'd7, 1, 1, RADIX_DEC, 63, 63, 1, 1, 0, 1, 0, 0));
        send_item(make_arg(64'd7, 1, 1, RADIX_HEX, 63, 63, 1, 0, 1, 1, 0, 1));
        send_item(make_arg(64'hFFFF_FFFF_FFFF_FFF0, 1, 1, RADIX_HEX, 8, 0, 0, 0, 0, 0, 0, 1));
        send_item(make_arg(64'h1234_5678_0000_00FF, 0, 0, RADIX_OCT, 0, 6, 1, 0, 0, 0, 0, 1));
    endtask

    task automatic test_random(int n, int idle_pct);
        sender_idle_pct = idle_pct;
        for (int i = 0; i < n; i++)
            send_item(random_arg());
    endtask

    task automatic test_drain_pause();
        start <= 1'b0;
        wait_drained();
        @(posedge clk);
        send_item(random_arg());
    endtask

    initial
    begin
        error_count = 0;
        sender_idle_pct = 0;
        start = 1'b0;
        arg = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_random(110, 20);
        test_drain_pause();
        test_random(110, 62);
        test_random(110, 0);
        start <= 1'b0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_chars.size() == 0)
            $display("** integer_to_padded_ascii_top: PASSED **");
        else
            $display("** integer_to_padded_ascii_top: FAILED **");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/itpa_pkg.sv
rtl/integer_to_padded_ascii_top.sv
dv/integer_to_padded_ascii_top_tb.sv
